### hdl/rvsc_pkg.sv
// ----------------------------------------------------------------------------
// rvsc_pkg - shared definitions of the RV64I subset core
// Opcodes, function codes, the memory access code and the result word type.
// ----------------------------------------------------------------------------
package rvsc_pkg;

	localparam int DataBytesDefault = 256;

	localparam logic [6:0] OpR    = 7'd51;
	localparam logic [6:0] OpI    = 7'd19;
	localparam logic [6:0] OpLd   = 7'd3;
	localparam logic [6:0] OpJalr = 7'd103;
	localparam logic [6:0] OpSd   = 7'd35;
	localparam logic [6:0] OpBr   = 7'd99;
	localparam logic [6:0] OpJal  = 7'd111;

	localparam logic [6:0] F7Base = 7'b0000000;
	localparam logic [6:0] F7Alt  = 7'b0100000;

	// ALU function codes
	localparam logic [2:0] F3Add = 3'd0;
	localparam logic [2:0] F3Sll = 3'd1;
	localparam logic [2:0] F3Slt = 3'd2;
	localparam logic [2:0] F3Dw  = 3'd3;
	localparam logic [2:0] F3Xor = 3'd4;
	localparam logic [2:0] F3Srl = 3'd5;
	localparam logic [2:0] F3Or  = 3'd6;

	// branch and jalr function codes
	localparam logic [2:0] F3Beq  = 3'd0;
	localparam logic [2:0] F3Bne  = 3'd1;
	localparam logic [2:0] F3Blt  = 3'd4;
	localparam logic [2:0] F3Bge  = 3'd5;
	localparam logic [2:0] F3Jalr = 3'd0;

	typedef enum logic [1:0] {
		AccNone  = 2'd0,
		AccLoad  = 2'd1,
		AccStore = 2'd2
	} acc_t;

	typedef struct packed {
		logic [31:0] npc;
		logic        wr;
		logic [4:0]  rd;
		logic [63:0] wval;
		acc_t        access;
		logic [7:0]  maddr;
		logic        illegal;
		logic        running;
	} res_t;

endpackage

### hdl/rvsc_exec.sv
// ----------------------------------------------------------------------------
// rvsc_exec - decode and execute
// Combinational decode, ALU, branch resolution and address generation.
// ----------------------------------------------------------------------------
module rvsc_exec #(
	parameter int DATA_BYTES = rvsc_pkg::DataBytesDefault
) (
	input  logic [31:0]                      ins,
	input  logic [31:0]                      pc,
	input  logic [63:0]                      a,
	input  logic [63:0]                      b,
	input  logic [31:0]                      last_addr,
	output rvsc_pkg::res_t                   res,
	output logic [$clog2(DATA_BYTES)-1:0]    mem_base
);

	localparam int AW = $clog2(DATA_BYTES);

	logic [6:0]  op;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [4:0]  rd;
	logic [63:0] imm_i;
	logic [63:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_j;
	logic [63:0] alu_b;
	logic        alt;
	logic [63:0] alu_out;
	logic [31:0] addr_sum;
	logic [31:0] base32;
	logic [31:0] pc4;
	logic        shift;
	logic        take;

	assign op = ins[6:0];
	assign f3 = ins[14:12];
	assign f7 = ins[31:25];
	assign rd = ins[11:7];

	assign imm_i = {{52{ins[31]}}, ins[31:20]};
	assign imm_s = {{52{ins[31]}}, ins[31:25], ins[11:7]};
	assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
	assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

	assign alu_b = (op == rvsc_pkg::OpR) ? b : imm_i;
	assign alt   = (op == rvsc_pkg::OpR) && (f7 == rvsc_pkg::F7Alt);
	assign shift = (f3 == rvsc_pkg::F3Sll) || (f3 == rvsc_pkg::F3Srl);

	// loads, stores and jalr share one address adder
	assign addr_sum = a[31:0] + ((op == rvsc_pkg::OpSd) ? imm_s[31:0] : imm_i[31:0]);
	assign base32   = addr_sum & 32'(DATA_BYTES - 1);
	assign mem_base = addr_sum[AW-1:0];
	assign pc4      = pc + 32'd4;

	always_comb begin
		case (f3)
			rvsc_pkg::F3Add: alu_out = alt ? (a - alu_b) : (a + alu_b);
			rvsc_pkg::F3Sll: alu_out = a << alu_b[5:0];
			rvsc_pkg::F3Slt: alu_out = {63'd0, $signed(a) < $signed(alu_b)};
			rvsc_pkg::F3Xor: alu_out = a ^ alu_b;
			rvsc_pkg::F3Srl: alu_out = a >> alu_b[5:0];
			rvsc_pkg::F3Or:  alu_out = a | alu_b;
			default:         alu_out = a & alu_b;
		endcase
	end

	always_comb begin
		take = 1'b0;
		res.npc     = pc4;
		res.wr      = 1'b0;
		res.rd      = rd;
		res.wval    = 64'd0;
		res.access  = rvsc_pkg::AccNone;
		res.maddr   = 8'd0;
		res.illegal = 1'b0;
		case (op)
			rvsc_pkg::OpR: begin
				if ((f3 != rvsc_pkg::F3Dw) && ((f7 == rvsc_pkg::F7Base) ||
						((f7 == rvsc_pkg::F7Alt) && (f3 == rvsc_pkg::F3Add)))) begin
					res.wr   = 1'b1;
					res.wval = alu_out;
				end else begin
					res.illegal = 1'b1;
				end
			end
			rvsc_pkg::OpI: begin
				if ((f3 != rvsc_pkg::F3Dw) && !(shift && (ins[31:26] != 6'd0))) begin
					res.wr   = 1'b1;
					res.wval = alu_out;
				end else begin
					res.illegal = 1'b1;
				end
			end
			rvsc_pkg::OpLd: begin
				if (f3 == rvsc_pkg::F3Dw) begin
					res.wr     = 1'b1;
					res.access = rvsc_pkg::AccLoad;
					res.maddr  = base32[7:0];
				end else begin
					res.illegal = 1'b1;
				end
			end
			rvsc_pkg::OpSd: begin
				if (f3 == rvsc_pkg::F3Dw) begin
					res.access = rvsc_pkg::AccStore;
					res.maddr  = base32[7:0];
				end else begin
					res.illegal = 1'b1;
				end
			end
			rvsc_pkg::OpBr: begin
				case (f3)
					rvsc_pkg::F3Beq: take = (a == b);
					rvsc_pkg::F3Bne: take = (a != b);
					rvsc_pkg::F3Blt: take = $signed(a) < $signed(b);
					rvsc_pkg::F3Bge: take = !($signed(a) < $signed(b));
					default:         res.illegal = 1'b1;
				endcase
				if (take) begin
					res.npc = pc + imm_b;
				end
			end
			rvsc_pkg::OpJal: begin
				res.wr   = 1'b1;
				res.wval = {32'd0, pc4};
				res.npc  = pc + imm_j;
			end
			rvsc_pkg::OpJalr: begin
				if (f3 == rvsc_pkg::F3Jalr) begin
					res.wr   = 1'b1;
					res.wval = {32'd0, pc4};
					res.npc  = {addr_sum[31:1], 1'b0};
				end else begin
					res.illegal = 1'b1;
				end
			end
			default: res.illegal = 1'b1;
		endcase
		// drop writes to x0
		if (!(res.wr && (rd != 5'd0))) begin
			res.wr   = 1'b0;
			res.wval = 64'd0;
			res.rd   = 5'd0;
		end
		res.running = (res.npc <= last_addr);
	end

endmodule

### hdl/rvsc_dmem.sv
// ----------------------------------------------------------------------------
// rvsc_dmem - banked data memory
// Eight byte banks give one doubleword per cycle at any byte address, with
// wrap-around, once a clearing pass has zeroed the banks after reset.
// ----------------------------------------------------------------------------
module rvsc_dmem #(
	parameter int DATA_BYTES = rvsc_pkg::DataBytesDefault
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req,
	input  logic                            we,
	input  logic [$clog2(DATA_BYTES)-1:0]   base,
	input  logic [63:0]                     wdata,
	output logic [63:0]                     rdata,
	output logic                            busy
);

	localparam int AW   = $clog2(DATA_BYTES);
	localparam int RW   = AW - 3;
	localparam int ROWS = DATA_BYTES / 8;

	logic [RW-1:0] base_row;
	logic [2:0]    off;
	logic [2:0]    off_q;
	logic          busy_q;
	logic [RW-1:0] clr_row_q;
	logic [7:0]    bank_rd [8];

	assign base_row = base[AW-1:3];
	assign off      = base[2:0];
	assign busy     = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_row_q <= '0;
		end else if (busy_q) begin
			clr_row_q <= clr_row_q + RW'(1);
			if (clr_row_q == RW'(ROWS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req) begin
			off_q <= off;
		end
	end

	for (genvar k = 0; k < 8; k++) begin : g_bank
		logic [7:0]    bank_mem [ROWS];
		logic [RW-1:0] row;
		logic [2:0]    lane;
		logic [7:0]    wbyte;
		logic [7:0]    rd_q;

		// banks below the start offset take the following row
		assign row   = (3'(k) >= off) ? base_row : base_row + RW'(1);
		assign lane  = 3'(k) - off;
		assign wbyte = wdata[{lane, 3'b000} +: 8];

		always_ff @(posedge clk) begin
			if (busy_q) begin
				bank_mem[clr_row_q] <= 8'd0;
			end else if (req && we) begin
				bank_mem[row] <= wbyte;
			end
			if (req) begin
				rd_q <= bank_mem[row];
			end
		end

		assign bank_rd[k] = rd_q;
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			rdata[8*i +: 8] = bank_rd[3'(off_q + 3'(i))];
		end
	end

endmodule

### hdl/riscv_single_cycle_core_top.sv
// ----------------------------------------------------------------------------
// riscv_single_cycle_core_top - RV64I subset core, one instruction per word
// Executes the instruction word fetched at its own PC and reports the result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / instruction): one word is the
//   instruction at the current PC; next_pc of each result tells the fetch
//   side where to read the following word.
//   Output channel (out_valid / out_stall / result fields): one word per
//   instruction, in order.
//   Config channel (cfg_valid / cfg_ready / last_instr_addr): always ready;
//   write only while the core is idle.
//   Each accepted word passes from the execute register into the result
//   register. Throughput: one instruction per cycle while out_stall is low,
//   set by the single execute stage; register file reads are registered at
//   acceptance and results still in flight are forwarded.
//   Reset: register file, PC and limit go to zero. The data memory is then
//   cleared one row of eight bytes a cycle, with in_stall high. DATA_BYTES
//   is a power of two.
//   Stall: while out_stall holds a result, one more word is taken into the
//   execute register; after that in_stall rises until the result drains.
// ----------------------------------------------------------------------------
module riscv_single_cycle_core_top #(
	parameter int DATA_BYTES = rvsc_pkg::DataBytesDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	// instruction channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        instruction,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        next_pc,
	output logic               reg_write_en,
	output logic [4:0]         reg_write_index,
	output logic signed [63:0] reg_write_value,
	output logic [1:0]         mem_access,
	output logic [7:0]         mem_address,
	output logic               illegal,
	output logic               running,
	// configuration channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        last_instr_addr
);

	localparam int AW = $clog2(DATA_BYTES);

	// handshakes
	logic in_acc;
	logic out_acc;
	logic adv1;

	// architectural state
	logic [31:0] pc_q;
	logic [31:0] last_addr_q;
	logic [63:0] rf_mem [32];
	logic [31:0] rf_vld_q;

	// execute stage
	logic        valid_s1;
	logic [31:0] ins_s1;
	logic [63:0] a_mem_s1;
	logic [63:0] b_mem_s1;
	logic        a_vld_s1;
	logic        b_vld_s1;
	logic        a_fwd_s1;
	logic        b_fwd_s1;
	logic [63:0] a_fv_s1;
	logic [63:0] b_fv_s1;
	logic [4:0]  rs1_s1;
	logic [4:0]  rs2_s1;
	logic [63:0] a_reg;
	logic [63:0] b_reg;
	logic [63:0] a_op;
	logic [63:0] b_op;

	rvsc_pkg::res_t res;
	logic [AW-1:0]  mem_base;

	// result stage
	logic           valid_s2;
	logic           wb_pend_s2;
	rvsc_pkg::res_t res_s2;
	logic           load_s2;
	logic [63:0]    ld_data;
	logic [63:0]    wb_val;
	logic           rf_we;
	logic [4:0]     rf_widx;

	logic dmem_busy;
	logic dmem_req;
	logic dmem_we;

	// Handshakes: the execute register moves on when the result register is
	// empty or being drained; a new word enters whenever execute is free or moving on and the data memory is not clearing.
	assign adv1      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = dmem_busy || (valid_s1 && !adv1);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = valid_s2 && !out_stall;
	assign cfg_ready = 1'b1;

	// Writeback: each result updates the register file in the cycle after it
	// lands in the result register, when the load data is available.
	assign load_s2 = (res_s2.access == rvsc_pkg::AccLoad) && res_s2.wr;
	assign wb_val  = load_s2 ? ld_data : res_s2.wval;
	assign rf_we   = wb_pend_s2 && res_s2.wr;
	assign rf_widx = res_s2.rd;

	// Operands: the registered read, patched by writes seen while the word
	// waited, then by the write still pending from the result stage.
	assign rs1_s1 = ins_s1[19:15];
	assign rs2_s1 = ins_s1[24:20];
	assign a_reg  = a_fwd_s1 ? a_fv_s1 : (a_vld_s1 ? a_mem_s1 : 64'd0);
	assign b_reg  = b_fwd_s1 ? b_fv_s1 : (b_vld_s1 ? b_mem_s1 : 64'd0);
	assign a_op   = (rf_we && (rf_widx == rs1_s1)) ? wb_val : a_reg;
	assign b_op   = (rf_we && (rf_widx == rs2_s1)) ? wb_val : b_reg;

	rvsc_exec #(
		.DATA_BYTES(DATA_BYTES)
	) u_exec (
		.ins      (ins_s1),
		.pc       (pc_q),
		.a        (a_op),
		.b        (b_op),
		.last_addr(last_addr_q),
		.res      (res),
		.mem_base (mem_base)
	);

	assign dmem_req = adv1 && (res.access != rvsc_pkg::AccNone);
	assign dmem_we  = (res.access == rvsc_pkg::AccStore);

	rvsc_dmem #(
		.DATA_BYTES(DATA_BYTES)
	) u_dmem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dmem_req),
		.we    (dmem_we),
		.base  (mem_base),
		.wdata (b_op),
		.rdata (ld_data),
		.busy  (dmem_busy)
	);

	// Control state: stage valids, PC, limit register and entry valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			wb_pend_s2  <= 1'b0;
			pc_q        <= 32'd0;
			last_addr_q <= 32'd0;
			rf_vld_q    <= 32'd0;
			a_vld_s1    <= 1'b0;
			b_vld_s1    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				last_addr_q <= last_instr_addr;
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
				a_vld_s1 <= rf_vld_q[instruction[19:15]];
				b_vld_s1 <= rf_vld_q[instruction[24:20]];
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
				pc_q     <= res.npc;
			end else if (out_acc) begin
				valid_s2 <= 1'b0;
			end
			wb_pend_s2 <= adv1;
			if (rf_we) begin
				rf_vld_q[rf_widx] <= 1'b1;
			end
		end
	end

	// Register file: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[rf_widx] <= wb_val;
		end
		if (in_acc) begin
			a_mem_s1 <= rf_mem[instruction[19:15]];
			b_mem_s1 <= rf_mem[instruction[24:20]];
		end
	end

	// Execute register payload and forwarding capture.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ins_s1   <= instruction;
			a_fwd_s1 <= rf_we && (rf_widx == instruction[19:15]);
			b_fwd_s1 <= rf_we && (rf_widx == instruction[24:20]);
			a_fv_s1  <= wb_val;
			b_fv_s1  <= wb_val;
		end else if (valid_s1) begin
			if (rf_we && (rf_widx == rs1_s1)) begin
				a_fwd_s1 <= 1'b1;
				a_fv_s1  <= wb_val;
			end
			if (rf_we && (rf_widx == rs2_s1)) begin
				b_fwd_s1 <= 1'b1;
				b_fv_s1  <= wb_val;
			end
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv1) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign next_pc         = res_s2.npc;
	assign reg_write_en    = res_s2.wr;
	assign reg_write_index = res_s2.rd;
	assign reg_write_value = $signed(wb_val);
	assign mem_access      = res_s2.access;
	assign mem_address     = res_s2.maddr;
	assign illegal         = res_s2.illegal;
	assign running         = res_s2.running;

endmodule

### verif/riscv_single_cycle_core_top_tb.sv
// ----------------------------------------------------------------------------
// riscv_single_cycle_core_top_tb - self-checking bench of the RV64I subset core
// Feeds instruction words through the stall handshake, executes each accepted
// word on a behavioral copy of the core (register file, PC, data memory,
// program limit) and checks every result word field by field, in order.
// Directed corner cases come first, then randomized phases, each phase under
// its own program limit, with random gaps and back-pressure on both channels except in one phase.
// ----------------------------------------------------------------------------
module riscv_single_cycle_core_top_tb;

	import rvsc_pkg::*;

	localparam int DataBytes = DataBytesDefault;
	localparam int IdleLimit = 1000;	// cycles with no handshake at all
	localparam int DrainCycles = 8;		// result register depth plus margin

	// ALU code missing from the package: f3 = 7 is "and"
	localparam logic [2:0] F3And = 3'd7;

	logic clk;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] instruction = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] next_pc;
	logic reg_write_en;
	logic [4:0] reg_write_index;
	logic signed [63:0] reg_write_value;
	logic [1:0] mem_access;
	logic [7:0] mem_address;
	logic illegal;
	logic running;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] last_instr_addr = '0;

	// architectural state of the core as the bench sees it
	logic [63:0] gpr [32];
	logic [7:0] dmem [DataBytes];
	logic [31:0] pc_model;
	logic [31:0] limit_model;

	logic [31:0] fetch_q [$];	// instruction words waiting to be sent
	res_t outcome_q [$];		// predicted result words, oldest first
	res_t want;

	int fail_count = 0;
	int idle_cycles = 0;
	logic no_idle = 1'b0;

	logic [2:0] alu_codes [7] = '{F3Add, F3Sll, F3Slt, F3Xor, F3Srl, F3Or, F3And};
	logic [2:0] br_codes [4] = '{F3Beq, F3Bne, F3Blt, F3Bge};
	logic [31:0] lim_table [6] = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'h0000_0400, 32'd0,
		32'h8000_0000};

	riscv_single_cycle_core_top #(
		.DATA_BYTES(DataBytes)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.instruction(instruction),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.next_pc(next_pc),
		.reg_write_en(reg_write_en),
		.reg_write_index(reg_write_index),
		.reg_write_value(reg_write_value),
		.mem_access(mem_access),
		.mem_address(mem_address),
		.illegal(illegal),
		.running(running),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.last_instr_addr(last_instr_addr)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Instruction encoders
	// ------------------------------------------------------------------------
	function automatic logic [31:0] r_word(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
		logic [2:0] f3, logic [4:0] rd);
		return {f7, rs2, rs1, f3, rd, OpR};
	endfunction

	function automatic logic [31:0] i_word(logic [6:0] op, logic [11:0] imm, logic [4:0] rs1,
		logic [2:0] f3, logic [4:0] rd);
		return {imm, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] s_word(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
		logic [2:0] f3);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OpSd};
	endfunction

	// imm[0] is implied zero and dropped
	function automatic logic [31:0] b_word(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
		logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OpBr};
	endfunction

	function automatic logic [31:0] j_word(logic [20:0] imm, logic [4:0] rd);
		return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OpJal};
	endfunction

	// mostly x0..x7 so that values get reused and built up
	function automatic logic [4:0] pick_reg();
		return ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
	endfunction

	// One undecodable word of the given kind; the last kind is an unknown opcode.
	function automatic logic [31:0] bad_word(int kind);
		logic [4:0] rs, rd;
		logic [2:0] f3;
		logic [6:0] op;
		logic [31:0] w;
		rs = pick_reg();
		rd = pick_reg();
		w = $urandom;
		// any load/store width except doubleword
		f3 = 3'($urandom_range(6));
		if (f3 >= F3Dw)
			f3 = f3 + 3'd1;
		case (kind)
			0: return r_word(F7Base, w[24:20], rs, F3Dw, rd);
			1: return r_word(F7Alt, w[24:20], rs, 3'($urandom_range(1, 7)), rd);
			// odd f7 is neither the base nor the alternate form
			2: return r_word(w[31:25] | 7'd1, w[24:20], rs, alu_codes[$urandom_range(6)], rd);
			3: return i_word(OpI, w[31:20], rs, F3Dw, rd);
			4: return i_word(OpI, {6'($urandom_range(1, 63)), w[25:20]}, rs,
				w[0] ? F3Sll : F3Srl, rd);
			// f3[1] set gives the four undefined branch conditions
			5: return b_word(w[12:0], w[24:20], rs, {w[1], 1'b1, w[2]});
			6: return i_word(OpLd, w[31:20], rs, f3, rd);
			7: return s_word(w[31:20], w[24:20], rs, f3);
			8: return i_word(OpJalr, w[31:20], rs, 3'($urandom_range(1, 7)), rd);
			default: begin
				op = w[6:0];
				while (op inside {OpR, OpI, OpLd, OpJalr, OpSd, OpBr, OpJal})
					op = 7'($urandom);
				return {w[31:7], op};
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Behavioral core
	// ------------------------------------------------------------------------
	function automatic logic [63:0] alu_result(logic [2:0] f3, logic alt, logic [63:0] a,
		logic [63:0] b);
		case (f3)
			F3Add: return alt ? a - b : a + b;
			F3Sll: return a << b[5:0];
			F3Slt: return ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
			F3Xor: return a ^ b;
			F3Srl: return a >> b[5:0];
			F3Or: return a | b;
			default: return a & b;
		endcase
	endfunction

	// Retire one instruction on the bench's state and return the result word.
	function automatic res_t execute_instr(logic [31:0] ins);
		res_t r;
		logic [6:0] op, f7;
		logic [4:0] rd, rs1, rs2;
		logic [2:0] f3;
		logic [63:0] a, b, imm_i, imm_s, imm_b, imm_j, wval;
		logic [31:0] npc;
		logic [7:0] base;
		logic wr, bad, take;
		int k;
		op = ins[6:0];
		rd = ins[11:7];
		f3 = ins[14:12];
		rs1 = ins[19:15];
		rs2 = ins[24:20];
		f7 = ins[31:25];
		a = gpr[rs1];
		b = gpr[rs2];
		imm_i = {{52{ins[31]}}, ins[31:20]};
		imm_s = {{52{ins[31]}}, ins[31:25], ins[11:7]};
		imm_b = {{52{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
		imm_j = {{44{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
		r = '0;
		npc = pc_model + 32'd4;
		wr = 1'b0;
		bad = 1'b0;
		take = 1'b0;
		wval = '0;
		case (op)
			OpR: begin
				if (f3 != F3Dw && (f7 == F7Base || (f7 == F7Alt && f3 == F3Add))) begin
					wr = 1'b1;
					wval = alu_result(f3, f7 == F7Alt, a, b);
				end else begin
					bad = 1'b1;
				end
			end
			OpI: begin
				if (f3 != F3Dw && !((f3 == F3Sll || f3 == F3Srl) && ins[31:26] != '0)) begin
					wr = 1'b1;
					wval = alu_result(f3, 1'b0, a, imm_i);
				end else begin
					bad = 1'b1;
				end
			end
			OpLd: begin
				if (f3 == F3Dw) begin
					base = 8'(a + imm_i);
					for (k = 0; k < 8; k++)
						wval[8*k +: 8] = dmem[base + 8'(k)];
					wr = 1'b1;
					r.access = AccLoad;
					r.maddr = base;
				end else begin
					bad = 1'b1;
				end
			end
			OpSd: begin
				if (f3 == F3Dw) begin
					base = 8'(a + imm_s);
					for (k = 0; k < 8; k++)
						dmem[base + 8'(k)] = b[8*k +: 8];
					r.access = AccStore;
					r.maddr = base;
				end else begin
					bad = 1'b1;
				end
			end
			OpBr: begin
				case (f3)
					F3Beq: take = (a == b);
					F3Bne: take = (a != b);
					F3Blt: take = ($signed(a) < $signed(b));
					F3Bge: take = ($signed(a) >= $signed(b));
					default: bad = 1'b1;
				endcase
				if (take)
					npc = pc_model + imm_b[31:0];
			end
			OpJal: begin
				wr = 1'b1;
				wval = {32'd0, pc_model + 32'd4};
				npc = pc_model + imm_j[31:0];
			end
			OpJalr: begin
				if (f3 == F3Jalr) begin
					wr = 1'b1;
					wval = {32'd0, pc_model + 32'd4};
					npc = (a[31:0] + imm_i[31:0]) & 32'hFFFF_FFFE;
				end else begin
					bad = 1'b1;
				end
			end
			default: bad = 1'b1;
		endcase
		// x0 stays zero and the write is not reported
		if (wr && rd != 5'd0) begin
			gpr[rd] = wval;
			r.wr = 1'b1;
			r.rd = rd;
			r.wval = wval;
		end
		pc_model = npc;
		r.npc = npc;
		r.illegal = bad;
		r.running = (npc <= limit_model);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Random program generation
	// ------------------------------------------------------------------------
	task automatic push_random(int n);
		int stop, pick;
		logic [4:0] rs, rt, rd;
		logic [11:0] imm;
		logic [2:0] f3;
		stop = fetch_q.size() + n;
		while (fetch_q.size() < stop) begin
			pick = $urandom_range(99);
			rs = pick_reg();
			rt = pick_reg();
			rd = pick_reg();
			imm = 12'($urandom);
			f3 = alu_codes[$urandom_range(6)];
			if (pick < 28) begin
				fetch_q.push_back(r_word((f3 == F3Add && $urandom_range(1)) ? F7Alt : F7Base,
					rt, rs, f3, rd));
			end else if (pick < 52) begin
				if (f3 == F3Sll || f3 == F3Srl)
					imm = {6'd0, imm[5:0]};
				fetch_q.push_back(i_word(OpI, imm, rs, f3, rd));
			end else if (pick < 66) begin
				// store, then read it back through the same base, sometimes
				// shifted by -8 to +7 bytes so the doublewords mostly overlap
				fetch_q.push_back(s_word(imm, rt, rs, F3Dw));
				if ($urandom_range(3) == 0)
					imm = imm + 12'($urandom_range(15)) - 12'd8;
				fetch_q.push_back(i_word(OpLd, imm, rs, F3Dw, rd));
			end else if (pick < 78) begin
				if ($urandom_range(3) == 0)
					rt = rs;
				fetch_q.push_back(b_word({imm, 1'b0}, rt, rs, br_codes[$urandom_range(3)]));
			end else if (pick < 83) begin
				fetch_q.push_back(j_word($urandom_range(1) ? {20'($urandom), 1'b0}
					: {{13{imm[7]}}, imm[7:1], 1'b0}, rd));
			end else if (pick < 87) begin
				fetch_q.push_back(i_word(OpJalr, imm, rs, F3Jalr, rd));
			end else if (pick < 94) begin
				fetch_q.push_back(bad_word($urandom_range(9)));
			end else begin
				fetch_q.push_back($urandom);
			end
		end
	endtask

	// Hold until every word is sent and every result has come back.
	task automatic drain();
		do @(negedge clk);
		while (fetch_q.size() != 0 || in_valid || outcome_q.size() != 0);
	endtask

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s expected %h got %h", $time, name, exp_v, got_v);
			fail_count++;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Instruction driver: present the next word only once the current one is
	// taken; a stalled word and its valid stay put. Each accepted word is
	// executed on the bench state right away, in acceptance order.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				outcome_q.push_back(execute_instr(instruction));
			if (!in_valid || !in_stall) begin
				if (fetch_q.size() != 0 && (no_idle || $urandom_range(99) >= 22)) begin
					in_valid <= 1'b1;
					instruction <= fetch_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor: random back-pressure, compare every taken result word
	// with the oldest prediction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= !no_idle && ($urandom_range(99) < 22);
			if (out_valid && !out_stall) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: result word with none outstanding, expected none got next_pc %h",
						$time, next_pc);
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					check_field("next_pc", want.npc, next_pc);
					check_field("reg_write_en", want.wr, reg_write_en);
					check_field("reg_write_index", want.rd, reg_write_index);
					check_field("reg_write_value", want.wval, reg_write_value);
					check_field("mem_access", want.access, mem_access);
					check_field("mem_address", want.maddr, mem_address);
					check_field("illegal", want.illegal, illegal);
					check_field("running", want.running, running);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: any handshake on any channel counts as progress.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer: reset, directed words, then randomized phases. The program
	// limit is only rewritten once the core has drained; the drain before each
	// write also makes the sender pause until all results are in.
	// ------------------------------------------------------------------------
	initial begin
		int phase, k;
		logic [31:0] lim;
		foreach (gpr[i])
			gpr[i] = '0;
		foreach (dmem[i])
			dmem[i] = '0;
		pc_model = '0;
		limit_model = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (phase = 0; phase < 6; phase++) begin
			if (phase > 0) begin
				drain();
				lim = (phase == 2) ? 32'($urandom) : lim_table[phase];
				@(posedge clk);
				cfg_valid <= 1'b1;
				last_instr_addr <= lim;
				do @(posedge clk);
				while (!cfg_ready);
				cfg_valid <= 1'b0;
				limit_model = lim;
			end
			@(negedge clk);
			// one phase with no gaps and no back-pressure
			no_idle = (phase == 3);
			if (phase == 0) begin
				fetch_q.push_back(i_word(OpI, 12'hFFF, 5'd0, F3Add, 5'd1));	// x1 = -1
				fetch_q.push_back(i_word(OpI, 12'h7FF, 5'd0, F3Add, 5'd2));	// largest imm
				fetch_q.push_back(i_word(OpI, 12'd63, 5'd1, F3Sll, 5'd3));	// x3 = min
				fetch_q.push_back(r_word(F7Alt, 5'd3, 5'd0, F3Add, 5'd4));	// 0 - min wraps
				fetch_q.push_back(r_word(F7Base, 5'd1, 5'd2, F3Sll, 5'd5));	// count from low 6 bits
				fetch_q.push_back(r_word(F7Base, 5'd2, 5'd3, F3Slt, 5'd6));	// signed compare
				fetch_q.push_back(r_word(F7Base, 5'd2, 5'd1, F3Xor, 5'd11));
				fetch_q.push_back(r_word(F7Base, 5'd1, 5'd3, F3Srl, 5'd12));	// no sign fill
				fetch_q.push_back(r_word(F7Base, 5'd3, 5'd2, F3Or, 5'd13));
				fetch_q.push_back(r_word(F7Base, 5'd3, 5'd1, F3And, 5'd14));
				fetch_q.push_back(i_word(OpI, 12'h000, 5'd3, F3Slt, 5'd15));
				fetch_q.push_back(i_word(OpI, 12'hFFF, 5'd2, F3Xor, 5'd16));
				fetch_q.push_back(i_word(OpI, 12'd63, 5'd1, F3Srl, 5'd17));
				fetch_q.push_back(i_word(OpI, 12'h800, 5'd3, F3Or, 5'd7));	// most negative imm
				fetch_q.push_back(i_word(OpI, 12'h800, 5'd1, F3And, 5'd18));
				// doubleword at the top of memory wraps to address 0
				fetch_q.push_back(s_word(12'd252, 5'd4, 5'd0, F3Dw));
				fetch_q.push_back(i_word(OpLd, 12'd252, 5'd0, F3Dw, 5'd8));
				fetch_q.push_back(b_word(13'h1000, 5'd0, 5'd0, F3Beq));	// farthest back
				fetch_q.push_back(b_word(13'h0FFE, 5'd2, 5'd1, F3Bne));	// farthest ahead
				fetch_q.push_back(b_word(13'd8, 5'd2, 5'd3, F3Blt));
				fetch_q.push_back(b_word(13'h1FFE, 5'd3, 5'd1, F3Bge));	// misaligned target
				fetch_q.push_back(j_word(21'h100000, 5'd9));			// farthest back
				fetch_q.push_back(i_word(OpJalr, 12'd1, 5'd1, F3Jalr, 5'd10));	// target sum wraps to zero
				fetch_q.push_back(r_word(F7Base, 5'd1, 5'd1, F3Add, 5'd0));	// write to x0
				for (k = 0; k <= 9; k++)
					fetch_q.push_back(bad_word(k));
			end
			push_random(205);
		end

		drain();
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
